// File: rtl/sample_zscore_normalizer_macros.svh
`ifndef SAMPLE_ZSCORE_NORMALIZER_MACROS_SVH
`define SAMPLE_ZSCORE_NORMALIZER_MACROS_SVH

// Plain clocked assertion, disabled while reset is active.
`define SZN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication in the same cycle.
`define SZN_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
    `SZN_ASSERT(label, clk, rst_n, (cond) |-> (expr), msg)

`endif

// File: rtl/szn_pkg.sv
package szn_pkg;

    localparam int MAX_SAMPLES_DEF = 64;
    localparam int N_W    = 7;
    localparam int D_W    = 38;
    localparam int HALF_W = 19;
    localparam int SQ_W   = 76;
    localparam int TOT_W  = 82;
    localparam int Q_W    = 56;
    localparam int STEP_W = 6;
    localparam int PP_STEPS   = 3;
    localparam int DIV_STEPS  = 56;
    localparam int ROOT_STEPS = 28;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               missing;
        logic               end_of_set;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] score;
        logic               score_valid;
        logic               final_score;
    } t_out_item;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DEV_RD,
        S_DEV_DIFF,
        S_DEV_MUL,
        S_DEV_ACC,
        S_EMIT_RD,
        S_EMIT_DIFF,
        S_EMIT_MUL,
        S_EMIT_SCALE,
        S_EMIT_DIV,
        S_EMIT_ROOT_INIT,
        S_EMIT_ROOT,
        S_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic diff;
        logic mul;
        logic acc;
        logic next_idx;
        logic idx_zero;
        logic scale;
        logic div;
        logic root_init;
        logic root;
        logic out_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic close;
        logic n_ge2;
        logic is_missing;
        logic idx_last;
        logic total_zero;
        logic mul_last;
        logic div_last;
        logic root_last;
        logic out_free;
    } t_status;

endpackage

// File: rtl/szn_stream_if.sv
interface szn_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/szn_ram.sv
module szn_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/szn_ctrl.sv
module szn_ctrl
    import szn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_status.in_valid && i_status.close) n_state = S_DEV_RD;
            end
            S_DEV_RD: begin
                n_state = i_status.n_ge2 ? S_DEV_DIFF : S_EMIT_RD;
            end
            S_DEV_DIFF: begin
                if (!i_status.is_missing) n_state = S_DEV_MUL;
                else if (i_status.idx_last) n_state = S_EMIT_RD;
                else n_state = S_DEV_RD;
            end
            S_DEV_MUL: begin
                if (i_status.mul_last) n_state = S_DEV_ACC;
            end
            S_DEV_ACC: begin
                n_state = i_status.idx_last ? S_EMIT_RD : S_DEV_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_DIFF;
            end
            S_EMIT_DIFF: begin
                if (i_status.is_missing || !i_status.n_ge2 || i_status.total_zero) begin
                    n_state = S_EMIT_OUT;
                end else begin
                    n_state = S_EMIT_MUL;
                end
            end
            S_EMIT_MUL: begin
                if (i_status.mul_last) n_state = S_EMIT_SCALE;
            end
            S_EMIT_SCALE: begin
                n_state = S_EMIT_DIV;
            end
            S_EMIT_DIV: begin
                if (i_status.div_last) n_state = S_EMIT_ROOT_INIT;
            end
            S_EMIT_ROOT_INIT: begin
                n_state = S_EMIT_ROOT;
            end
            S_EMIT_ROOT: begin
                if (i_status.root_last) n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (i_status.out_free) begin
                    n_state = i_status.idx_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = 1'b1;
            end
            S_DEV_RD: begin
                o_cmd.rd = i_status.n_ge2;
            end
            S_DEV_DIFF: begin
                o_cmd.diff = 1'b1;
                if (i_status.is_missing) begin
                    o_cmd.idx_zero = i_status.idx_last;
                    o_cmd.next_idx = !i_status.idx_last;
                end
            end
            S_DEV_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_DEV_ACC: begin
                o_cmd.acc      = 1'b1;
                o_cmd.idx_zero = i_status.idx_last;
                o_cmd.next_idx = !i_status.idx_last;
            end
            S_EMIT_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_EMIT_DIFF: begin
                o_cmd.diff = 1'b1;
            end
            S_EMIT_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_EMIT_SCALE: begin
                o_cmd.scale = 1'b1;
            end
            S_EMIT_DIV: begin
                o_cmd.div = 1'b1;
            end
            S_EMIT_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
            end
            S_EMIT_ROOT: begin
                o_cmd.root = 1'b1;
            end
            S_EMIT_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = i_status.idx_last;
                    o_cmd.next_idx = !i_status.idx_last;
                end
            end
            default: o_cmd = '0;
        endcase
    end
endmodule

// File: rtl/szn_datapath.sv
`include "sample_zscore_normalizer_macros.svh"

module szn_datapath
    import szn_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    szn_stream_if.sink    i_in,
    szn_stream_if.source  o_out
);
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CW   = AW + 1;
    localparam int SUMW = 32 + AW;

    logic signed [SUMW-1:0] r_sum;
    logic [CW-1:0]          r_present;
    logic [CW-1:0]          r_loaded;
    logic [AW-1:0]          r_idx;
    logic [STEP_W-1:0]      r_step;
    logic [D_W-1:0]         r_dabs;
    logic                   r_neg;
    logic [SQ_W-1:0]        r_sq;
    logic [TOT_W-1:0]       r_total;
    logic [TOT_W-1:0]       r_rem;
    logic [Q_W-1:0]         r_dl;
    logic [Q_W-1:0]         r_q;
    logic [Q_W-1:0]         r_sqv;
    logic [Q_W-1:0]         r_res;
    logic [Q_W-1:0]         r_bit;
    logic                   r_out_valid;
    t_out_item              r_out;

    t_in_item w_item;
    logic     w_fire;
    logic [32:0] w_rdata;

    assign w_item = i_in.payload;
    assign w_fire = i_in.valid && i_cmd.load;
    assign i_in.ready = i_cmd.load;

    szn_ram #(
        .WIDTH (33),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_loaded[AW-1:0]),
        .i_wdata ({w_item.missing, w_item.sample}),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    logic signed [31:0] w_x;
    logic [N_W-1:0]     w_n7;
    logic signed [7:0]  w_n_s;
    logic signed [39:0] w_nx;
    logic signed [39:0] w_d;
    logic [39:0]        w_dabs;

    assign w_x    = signed'(w_rdata[31:0]);
    assign w_n7   = N_W'(r_present);
    assign w_n_s  = signed'({1'b0, w_n7});
    assign w_nx   = w_n_s * w_x;
    assign w_d    = w_nx - 40'(r_sum);
    assign w_dabs = w_d[39] ? 40'(-w_d) : w_d;

    logic [HALF_W-1:0]   w_pa;
    logic [HALF_W-1:0]   w_pb;
    logic [2*HALF_W-1:0] w_prod;
    logic [SQ_W-1:0]     w_pp;

    always_comb begin
        w_pa = r_dabs[HALF_W-1:0];
        w_pb = r_dabs[HALF_W-1:0];
        w_pp = SQ_W'(w_prod);
        case (r_step)
            STEP_W'(1): begin
                w_pa = r_dabs[D_W-1:HALF_W];
                w_pp = SQ_W'(w_prod) << (HALF_W + 1);
            end
            STEP_W'(2): begin
                w_pa = r_dabs[D_W-1:HALF_W];
                w_pb = r_dabs[D_W-1:HALF_W];
                w_pp = SQ_W'(w_prod) << (2 * HALF_W);
            end
            default: begin
                w_pa = r_dabs[HALF_W-1:0];
            end
        endcase
    end

    assign w_prod = w_pa * w_pb;

    logic [TOT_W-1:0] w_scaled;
    logic [TOT_W:0]   w_trial;
    logic             w_ge;
    logic [Q_W-1:0]   w_root_try;

    assign w_scaled   = r_sq * TOT_W'(w_n7 - N_W'(1));
    assign w_trial    = {r_rem, r_dl[Q_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_total};
    assign w_root_try = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_present <= '0;
            r_loaded  <= '0;
            r_idx     <= '0;
            r_total   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_sum     <= '0;
                r_present <= '0;
                r_loaded  <= '0;
                r_total   <= '0;
            end else if (w_fire) begin
                r_loaded <= r_loaded + CW'(1);
                if (!w_item.missing) begin
                    r_sum     <= r_sum + SUMW'(w_item.sample);
                    r_present <= r_present + CW'(1);
                end
            end else if (i_cmd.acc) begin
                r_total <= r_total + TOT_W'(r_sq);
            end
            if (i_cmd.clear || i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.next_idx) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.diff || i_cmd.scale || i_cmd.root_init) begin
            r_step <= '0;
        end else if (i_cmd.mul || i_cmd.div || i_cmd.root) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_dabs <= w_dabs[D_W-1:0];
            r_neg  <= w_d[39];
            r_sq   <= '0;
        end
        if (i_cmd.mul) begin
            r_sq <= r_sq + w_pp;
        end
        if (i_cmd.scale) begin
            r_rem <= TOT_W'(w_scaled[TOT_W-1:8]);
            r_dl  <= {w_scaled[7:0], 48'b0};
            r_q   <= '0;
        end
        if (i_cmd.div) begin
            r_rem <= w_ge ? TOT_W'(w_trial - {1'b0, r_total}) : w_trial[TOT_W-1:0];
            r_dl  <= {r_dl[Q_W-2:0], 1'b0};
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
        if (i_cmd.root_init) begin
            r_sqv <= r_q;
            r_res <= '0;
            r_bit <= Q_W'(1) << (2 * (ROOT_STEPS - 1));
        end
        if (i_cmd.root) begin
            if (r_sqv >= w_root_try) begin
                r_sqv <= r_sqv - w_root_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    logic        w_valid;
    logic [31:0] w_mag;
    logic        w_idx_last;

    assign w_valid    = !w_rdata[32] && o_status.n_ge2;
    assign w_mag      = r_res[31:0];
    assign w_idx_last = (CW'(r_idx) + CW'(1)) == r_loaded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.score_valid <= w_valid;
            r_out.final_score <= w_idx_last;
            if (w_valid && !o_status.total_zero) begin
                r_out.score <= r_neg ? signed'(-w_mag) : signed'(w_mag);
            end else begin
                r_out.score <= '0;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign o_status.in_valid   = i_in.valid;
    assign o_status.close      = w_item.end_of_set
                              || ((r_loaded + CW'(1)) == CW'(MAX_SAMPLES));
    assign o_status.n_ge2      = r_present >= CW'(2);
    assign o_status.is_missing = w_rdata[32];
    assign o_status.idx_last   = w_idx_last;
    assign o_status.total_zero = r_total == '0;
    assign o_status.mul_last   = r_step == STEP_W'(PP_STEPS - 1);
    assign o_status.div_last   = r_step == STEP_W'(DIV_STEPS - 1);
    assign o_status.root_last  = r_step == STEP_W'(ROOT_STEPS - 1);
    assign o_status.out_free   = !r_out_valid || o_out.ready;

    `SZN_ASSERT(a_present_le_loaded, i_clk, i_rst_n, r_present <= r_loaded, "present count above loaded count")
    `SZN_ASSERT_IMP(a_rem_below_total, i_clk, i_rst_n, i_cmd.div, r_rem < r_total, "division remainder out of range")
    `SZN_ASSERT_IMP(a_out_load_free, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || o_out.ready, "result register overwritten")
    `SZN_ASSERT_IMP(a_rd_in_set, i_clk, i_rst_n, i_cmd.rd, CW'(r_idx) < r_loaded, "read beyond the loaded set")
endmodule

// File: rtl/sample_zscore_normalizer.sv
// Loading takes one sample per cycle; the last sample of a set starts the statistics pass.
// The deviation pass squares and sums the deviation of each present sample. Each result
// passes the 56-step divider and the 28-step root unit unless its score is forced to
// zero; no sample is taken until the set is emitted. Synchronous active-low reset
// empties the set and the result register.
module sample_zscore_normalizer
    import szn_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    szn_stream_if.sink   i_in,
    szn_stream_if.source o_out
);
    t_cmd    w_cmd;
    t_status w_status;

    szn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    szn_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_in     (i_in),
        .o_out    (o_out)
    );
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import szn_pkg::*;

    localparam int CAPACITY = MAX_SAMPLES_DEF;

    typedef struct {
        logic signed [31:0] sample;
        logic               missing;
        logic               end_of_set;
        bit                 typed;
        logic signed [31:0] score;
        logic               score_valid;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    bit   long_hold;
    bit   sender_idle_free;

    szn_stream_if #(.t_payload(t_in_item))  in_if ();
    szn_stream_if #(.t_payload(t_out_item)) out_if ();

    sample_zscore_normalizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_out_item score_queue[$];
    t_row      open_set[$];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #20ms;
        $display("sample_zscore_normalizer: mismatch");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned q);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > q) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (q >= res + bitv) begin
                q = q - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Closes the open set and queues one z-score per loaded sample.
    task automatic predict_scores();
        longint          sum;
        longint          n;
        longint          dev;
        logic [167:0]    total;
        logic [167:0]    num;
        logic [167:0]    quot;
        longint unsigned mag;
        t_out_item       res;
        sum = 0;
        n = 0;
        total = '0;
        foreach (open_set[i]) begin
            if (!open_set[i].missing) begin
                sum = sum + longint'(open_set[i].sample);
                n++;
            end
        end
        if (n >= 2) begin
            foreach (open_set[i]) begin
                if (!open_set[i].missing) begin
                    dev = n * longint'(open_set[i].sample) - sum;
                    if (dev < 0) dev = -dev;
                    total = total + 168'(dev) * 168'(dev);
                end
            end
        end
        foreach (open_set[i]) begin
            res.score = '0;
            res.score_valid = 1'b0;
            res.final_score = (i == open_set.size() - 1);
            if (n >= 2 && !open_set[i].missing) begin
                res.score_valid = 1'b1;
                if (total != 0) begin
                    dev = n * longint'(open_set[i].sample) - sum;
                    num = (dev < 0) ? 168'(-dev) : 168'(dev);
                    num = ((num * num) * 168'(n - 1)) << 48;
                    quot = num / total;
                    mag = int_sqrt(quot[63:0]);
                    if (dev < 0) begin
                        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
                        res.score = -mag[31:0];
                    end else begin
                        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
                        res.score = mag[31:0];
                    end
                end
            end
            if (open_set[i].typed) begin
                res.score = open_set[i].score;
                res.score_valid = open_set[i].score_valid;
            end
            score_queue.push_back(res);
        end
        open_set.delete();
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_sample(t_row row);
        in_if.valid <= 1'b1;
        in_if.payload <= '{sample: row.sample, missing: row.missing,
                           end_of_set: row.end_of_set};
        do @(posedge i_clk); while (!in_if.ready);
        open_set.push_back(row);
        if (row.end_of_set || open_set.size() == CAPACITY) predict_scores();
        @(negedge i_clk);
    endtask

    int burst_left;

    task automatic pace();
        int gap;
        if (burst_left > 0 || sender_idle_free) begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 8);
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge i_clk);
        burst_left = $urandom_range(1, 20);
    endtask

    function automatic t_row plain_row(logic signed [31:0] s, logic m, logic e);
        t_row r;
        r.sample = s;
        r.missing = m;
        r.end_of_set = e;
        r.typed = 1'b0;
        r.score = '0;
        r.score_valid = 1'b0;
        return r;
    endfunction

    function automatic t_row typed_row(logic signed [31:0] s, logic m, logic e,
                                       logic signed [31:0] sc, logic v);
        t_row r;
        r = plain_row(s, m, e);
        r.typed = 1'b1;
        r.score = sc;
        r.score_valid = v;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (score_queue.size() == 0) begin
                report_mismatch("unexpected score", out_if.payload.score, 0);
            end else begin
                if (out_if.payload.score !== score_queue[0].score)
                    report_mismatch("score", out_if.payload.score, score_queue[0].score);
                if (out_if.payload.score_valid !== score_queue[0].score_valid)
                    report_mismatch("score_valid", out_if.payload.score_valid,
                                    score_queue[0].score_valid);
                if (out_if.payload.final_score !== score_queue[0].final_score)
                    report_mismatch("final_score", out_if.payload.final_score,
                                    score_queue[0].final_score);
                void'(score_queue.pop_front());
            end
        end
    end

    initial begin
        int cnt;
        int mode;
        out_if.ready = 1'b0;
        cnt = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_if.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end
            cnt++;
            if (cnt % 150 == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= ($urandom_range(0, 9) < 7);
                default: out_if.ready <= ((cnt % 11) > 3);
            endcase
        end
    end

    initial begin
        t_row  rows[$];
        int    items;
        int    size;
        int    base;
        int    spread;
        logic  miss;
        logic  eos;
        logic signed [31:0] s;
        int    waited;

        errors = 0;
        long_hold = 1'b0;
        sender_idle_free = 1'b0;
        burst_left = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        rows.push_back(typed_row(32'sd12345, 1'b0, 1'b1, 32'sd0, 1'b0));
        rows.push_back(plain_row(32'h8000_0000, 1'b0, 1'b0));
        rows.push_back(plain_row(32'h7FFF_FFFF, 1'b0, 1'b1));
        rows.push_back(typed_row(32'sd99, 1'b1, 1'b0, 32'sd0, 1'b0));
        rows.push_back(typed_row(32'sd5, 1'b0, 1'b0, 32'sd0, 1'b1));
        rows.push_back(typed_row(32'sd5, 1'b0, 1'b1, 32'sd0, 1'b1));
        rows.push_back(typed_row(32'sd1, 1'b1, 1'b0, 32'sd0, 1'b0));
        rows.push_back(typed_row(-32'sd1, 1'b1, 1'b1, 32'sd0, 1'b0));
        rows.push_back(plain_row(32'sd65536, 1'b0, 1'b0));
        rows.push_back(plain_row(32'sd7, 1'b1, 1'b0));
        rows.push_back(plain_row(-32'sd65536, 1'b0, 1'b1));
        rows.push_back(typed_row(32'h7FFF_FFFF, 1'b0, 1'b0, 32'sd0, 1'b1));
        rows.push_back(typed_row(32'h7FFF_FFFF, 1'b0, 1'b1, 32'sd0, 1'b1));
        rows.push_back(plain_row(32'h8000_0000, 1'b0, 1'b0));
        rows.push_back(plain_row(32'h8000_0000, 1'b0, 1'b0));
        rows.push_back(plain_row(32'h7FFF_FFFF, 1'b0, 1'b1));
        foreach (rows[i]) begin
            pace();
            send_sample(rows[i]);
        end

        long_hold = 1'b1;
        items = 0;
        while (items < 300) begin
            case ($urandom_range(0, 29))
                0: size = 1;
                1: size = CAPACITY;
                default: size = $urandom_range(2, 8);
            endcase
            base = $urandom;
            spread = $urandom_range(0, 3);
            sender_idle_free = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < size; k++) begin
                case (spread)
                    0: s = $urandom;
                    1: s = base + $signed($urandom_range(0, 255)) - 128;
                    2: s = base;
                    default: s = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
                endcase
                miss = ($urandom_range(0, 6) == 0);
                if (k == size - 1) eos = (size == CAPACITY) ? 1'($urandom_range(0, 1)) : 1'b1;
                else eos = ($urandom_range(0, 40) == 0);
                pace();
                send_sample(plain_row(s, miss, eos));
                items++;
                if (eos) break;
            end
        end
        in_if.valid <= 1'b0;

        waited = 0;
        while (score_queue.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (errors == 0 && score_queue.size() == 0 && open_set.size() == 0) begin
            $display("sample_zscore_normalizer: match");
        end else begin
            $display("sample_zscore_normalizer: mismatch");
        end
        $finish;
    end
endmodule
